FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/sacc_pkg.sv
package sacc_pkg;

  localparam int OUT_W      = 32;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTANCE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MODES    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MODE  = 2'd3;

  // Operations
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Per-field accumulation modes; the remaining codes act as none
  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_MAX  = 3'd1;
  localparam logic [2:0] MODE_MIN  = 3'd2;
  localparam logic [2:0] MODE_MEAN = 3'd3;
  localparam logic [2:0] MODE_SUM  = 3'd4;
  localparam logic [2:0] MODE_LAST = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [2:0]  instance_sel;
    logic [2:0]  field_sel;
    logic [31:0] sample_value;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0]   result_value;
    logic [COUNT_W-1:0] sample_count;
    logic               baseline_only;
    logic               bad_index;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;       // zero one table entry, advance the sweep
    logic load;      // capture the word and its address
    logic rd;        // read the addressed entry
    logic update;    // evaluate the entry, commit or start the divider
    logic div_step;  // one quotient bit
    logic finish;    // commit the mean result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

FILE: rtl/core/sacc_ctrl.sv
module sacc_ctrl import sacc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_FETCH  = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.need_div ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: rtl/core/sacc_dpath.sv
module sacc_dpath import sacc_pkg::*; #(
  parameter int MAX_INSTANCES = 8,
  parameter int MAX_FIELDS    = 8,
  parameter int VALUE_BITS    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  item_t                 item_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output result_t               result_o,
  output logic                  result_valid_o
);

  localparam int Depth = MAX_INSTANCES * MAX_FIELDS;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int MulW  = (IdxW > 7) ? IdxW : 7;
  localparam int StepW = $clog2(VALUE_BITS);

  typedef struct packed {
    logic [VALUE_BITS-1:0] run;
    logic [OUT_W-1:0]      shown;
    logic [COUNT_W-1:0]    count;
    logic [VALUE_BITS-1:0] prev;
    logic                  seen;
  } entry_t;

  // Configuration registers
  logic [3:0]  field_count_q;
  logic [3:0]  instance_count_q;
  logic [23:0] field_modes_q;
  logic        interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_count_q    <= 4'd1;
      instance_count_q <= 4'd1;
      field_modes_q    <= '0;
      interval_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIELD_COUNT:    field_count_q    <= cfg_data_i[3:0];
        CFG_INSTANCE_COUNT: instance_count_q <= cfg_data_i[3:0];
        CFG_FIELD_MODES:    field_modes_q    <= cfg_data_i[23:0];
        CFG_INTERVAL_MODE:  interval_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Address decode at load
  logic [3:0]      fc_eff, ic_eff;
  logic            bad_d;
  logic [MulW-1:0] idx_full;

  assign fc_eff = (int'(field_count_q) > MAX_FIELDS) ? 4'(MAX_FIELDS) : field_count_q;
  assign ic_eff = (int'(instance_count_q) > MAX_INSTANCES) ? 4'(MAX_INSTANCES)
                                                            : instance_count_q;
  assign bad_d  = ({1'b0, item_i.instance_sel} >= ic_eff) ||
                  ({1'b0, item_i.field_sel} >= fc_eff);
  assign idx_full = MulW'(item_i.instance_sel) * MulW'(fc_eff) + MulW'(item_i.field_sel);

  logic                  op_q;
  logic                  bad_q;
  logic [2:0]            mode_q;
  logic [VALUE_BITS-1:0] sample_q;
  logic [IdxW-1:0]       idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= item_i.operation;
      bad_q    <= bad_d;
      mode_q   <= field_modes_q[item_i.field_sel * 3 +: 3];
      sample_q <= VALUE_BITS'(item_i.sample_value);
      idx_q    <= idx_full[IdxW-1:0];
    end
  end

  // Clearing sweep after reset
  logic [IdxW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Entry update
  entry_t                rdata_q;
  entry_t                nxt;
  logic [VALUE_BITS-1:0] v;
  logic [COUNT_W-1:0]    cnt_inc;
  logic                  base;
  logic                  need_div;
  logic                  push_ok;

  assign push_ok = (op_q == OP_PUSH) && !bad_q;

  always_comb begin
    nxt      = rdata_q;
    base     = 1'b0;
    need_div = 1'b0;
    v        = interval_q ? (sample_q - rdata_q.prev) : sample_q;
    cnt_inc  = (rdata_q.count == '1) ? rdata_q.count : rdata_q.count + 1'b1;
    if (push_ok) begin
      if (interval_q && !rdata_q.seen) begin
        nxt.seen = 1'b1;
        nxt.prev = sample_q;
        base     = 1'b1;
      end else begin
        nxt.prev  = sample_q;
        nxt.count = cnt_inc;
        if (cnt_inc == COUNT_W'(1)) begin
          nxt.run   = v;
          nxt.shown = OUT_W'(v);
        end else begin
          case (mode_q)
            MODE_MAX: begin
              if (rdata_q.run < v) nxt.run = v;
              nxt.shown = OUT_W'(nxt.run);
            end
            MODE_MIN: begin
              if (rdata_q.run > v) nxt.run = v;
              nxt.shown = OUT_W'(nxt.run);
            end
            MODE_MEAN: begin
              nxt.run  = rdata_q.run + v;
              need_div = 1'b1;
            end
            MODE_SUM: begin
              nxt.run   = rdata_q.run + v;
              nxt.shown = OUT_W'(nxt.run);
            end
            MODE_LAST: begin
              nxt.run   = v;
              nxt.shown = OUT_W'(v);
            end
            default: ;
          endcase
        end
      end
    end
  end

  // Restoring divider: running sum over count, one quotient bit per cycle
  entry_t                pend_q;
  logic [VALUE_BITS-1:0] quo_q;
  logic [COUNT_W-1:0]    rem_q;
  logic [StepW-1:0]      step_q;
  logic [COUNT_W:0]      rem_sh;
  logic [COUNT_W:0]      rem_diff;
  logic                  qbit;

  assign rem_sh   = {rem_q, quo_q[VALUE_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, pend_q.count};
  assign qbit     = (rem_sh >= {1'b0, pend_q.count});

  always_ff @(posedge clk_i) begin
    if (cmd_i.update && need_div) begin
      pend_q <= nxt;
      quo_q  <= nxt.run;
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= qbit ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      quo_q  <= {quo_q[VALUE_BITS-2:0], qbit};
      step_q <= step_q + 1'b1;
    end
  end

  // Table memory: one write and one registered read per cycle
  entry_t          mem [Depth];
  logic            commit;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  entry_t          mem_wd;
  entry_t          fin_word;

  assign commit = (cmd_i.update && !need_div) || cmd_i.finish;
  assign mem_we = cmd_i.clr || (commit && push_ok);
  assign mem_wa = cmd_i.clr ? clr_q : idx_q;

  always_comb begin
    fin_word       = pend_q;
    fin_word.shown = OUT_W'(quo_q);
    if (cmd_i.clr) begin
      mem_wd = '0;
    end else if (cmd_i.finish) begin
      mem_wd = fin_word;
    end else begin
      mem_wd = nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.rd) rdata_q <= mem[idx_q];
  end

  // Result word
  result_t res_d;
  result_t res_q;
  logic    res_valid_q;

  always_comb begin
    res_d.result_value  = bad_q ? '0 : nxt.shown;
    res_d.sample_count  = bad_q ? '0 : nxt.count;
    res_d.baseline_only = base;
    res_d.bad_index     = bad_q;
    if (cmd_i.finish) begin
      res_d.result_value  = fin_word.shown;
      res_d.sample_count  = fin_word.count;
      res_d.baseline_only = 1'b0;
      res_d.bad_index     = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= commit;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  assign status_o.clr_last = (clr_q == IdxW'(Depth - 1));
  assign status_o.need_div = need_div;
  assign status_o.div_last = (step_q == StepW'(VALUE_BITS - 1));

endmodule

FILE: rtl/core/stats_accumulator_table_top.sv
// Sequence: a taken word is read from the table, then updated and written back, and its result
//   word strobes from a register; a mean update past an entry's first sample first runs the
//   restoring divider, one quotient bit a cycle, and is committed in a finish step. No new word
//   is taken until the last is written back; busy is low again in the strobe cycle.
// Reset: asynchronous, active low; busy then stays high while the MAX_INSTANCES * MAX_FIELDS
//   table entries (64 by default) are swept to zero. Results cannot be stalled.
`include "assert_macros.svh"

module stats_accumulator_table_top import sacc_pkg::*; #(
  parameter int MAX_INSTANCES = 8,
  parameter int MAX_FIELDS    = 8,
  parameter int VALUE_BITS    = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Command side: a word is taken when start is high and busy is low
  input  logic                  start,
  input  item_t                 item_i,
  output logic                  busy,
  // Result side: one-cycle strobe, no back-pressure
  output result_t               result_o,
  output logic                  result_valid_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: sweeps the table after reset, then walks each word through
  // fetch, update and (for mean) the divider iterations.
  sacc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Datapath: config registers, address decode, entry table, update logic,
  // divider and the result register.
  sacc_dpath #(
    .MAX_INSTANCES (MAX_INSTANCES),
    .MAX_FIELDS    (MAX_FIELDS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // A taken word keeps the block busy in the following cycle.
  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, (start && !busy) |=> busy)

  // A result only follows a busy cycle, and strobes never run back to back.
  `ASSERT_RST(a_result_after_busy, clk_i, rst_ni, result_valid_o |-> $past(busy))
  `ASSERT_RST(a_result_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o)

  // A bad address reports nothing but the flag.
  `ASSERT_NEVER(a_bad_clean, clk_i, rst_ni,
                result_valid_o && result_o.bad_index &&
                (result_o.result_value != '0 || result_o.sample_count != '0 ||
                 result_o.baseline_only))

endmodule

FILE: test/stats_accumulator_table_top_tb.sv
`timescale 1ns / 100ps

module stats_accumulator_table_top_tb;
  import sacc_pkg::*;

  localparam int MAX_INSTANCES = 8;
  localparam int MAX_FIELDS    = 8;
  localparam int VALUE_BITS    = 32;
  localparam int TABLE_DEPTH   = MAX_INSTANCES * MAX_FIELDS;
  // Worst case is a mean update per word plus sender gaps, far below this.
  localparam int CYCLE_LIMIT   = 500_000;

  // Codes 6 and 7 of a field mode behave like none
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  // Field 0 at the low end: one field per mode, both spare codes on top
  localparam logic [CFG_DATA_W-1:0] MIXED_MODES = {MODE_SPARE7, MODE_SPARE6, MODE_NONE,
                                                   MODE_LAST, MODE_SUM, MODE_MEAN,
                                                   MODE_MIN, MODE_MAX};
  localparam logic [CFG_DATA_W-1:0] ALL_MEAN    = 24'o33333333;
  localparam logic [CFG_DATA_W-1:0] ALL_SPARE   = 24'o77777777;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  cmd_start = 1'b0;
  item_t                 cmd_word = '0;
  logic                  cmd_busy;
  result_t               res_word;
  logic                  res_strobe;

  stats_accumulator_table_top #(
    .MAX_INSTANCES (MAX_INSTANCES),
    .MAX_FIELDS    (MAX_FIELDS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .start          (cmd_start),
    .item_i         (cmd_word),
    .busy           (cmd_busy),
    .result_o       (res_word),
    .result_valid_o (res_strobe)
  );

  // Command words waiting to be sent, and the result words the table owes us
  item_t   pending_words[$];
  result_t expected_results[$];

  int words_accepted    = 0;
  int results_checked   = 0;
  int error_count       = 0;
  int register_settings = 0;
  int cycle_count       = 0;

  // Shadow of the register file, as last written
  logic [3:0]            field_count_cfg    = 4'd1;
  logic [3:0]            instance_count_cfg = 4'd1;
  logic [CFG_DATA_W-1:0] field_modes_cfg    = '0;
  logic                  interval_cfg       = 1'b0;

  // Shadow of the accumulator table
  logic [VALUE_BITS-1:0] acc_value      [TABLE_DEPTH];
  logic [OUT_W-1:0]      shown_value    [TABLE_DEPTH];
  logic [COUNT_W-1:0]    sample_tally   [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] last_sample    [TABLE_DEPTH];
  logic                  baseline_taken [TABLE_DEPTH];

  // Sender runs without gaps over one stretch of the random traffic
  logic quiet_stretch;
  assign quiet_stretch = (words_accepted >= 400) && (words_accepted < 560);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Counts above the table size act as the table size; zero makes all addresses bad.
  function automatic int unsigned clamp_count(logic [3:0] cnt, int unsigned top);
    return (cnt > top) ? top : int'(cnt);
  endfunction

  // Apply one command word to the shadow table and return the result word it earns.
  function automatic result_t apply_to_table(item_t w);
    result_t          r;
    int unsigned      fc;
    int unsigned      ic;
    int unsigned      idx;
    logic [31:0]      v;
    logic [2:0]       mode;
    r  = '0;
    fc = clamp_count(field_count_cfg, MAX_FIELDS);
    ic = clamp_count(instance_count_cfg, MAX_INSTANCES);
    if (int'(w.instance_sel) >= ic || int'(w.field_sel) >= fc) begin
      r.bad_index = 1'b1;
    end else begin
      idx = int'(w.instance_sel) * fc + int'(w.field_sel);
      if (w.operation == OP_PUSH) begin
        v = w.sample_value;
        if (interval_cfg) begin
          // First push of an entry only records the baseline
          if (!baseline_taken[idx]) begin
            baseline_taken[idx] = 1'b1;
            last_sample[idx]    = w.sample_value;
            r.baseline_only     = 1'b1;
          end else begin
            v = w.sample_value - last_sample[idx];
          end
        end
        if (!r.baseline_only) begin
          last_sample[idx] = w.sample_value;
          if (sample_tally[idx] != '1) sample_tally[idx] = sample_tally[idx] + 1'b1;
          mode = field_modes_cfg[3*w.field_sel +: 3];
          if (sample_tally[idx] == 1) begin
            acc_value[idx]   = v;
            shown_value[idx] = v;
          end else begin
            case (mode)
              MODE_MAX: begin
                if (acc_value[idx] < v) acc_value[idx] = v;
                shown_value[idx] = acc_value[idx];
              end
              MODE_MIN: begin
                if (acc_value[idx] > v) acc_value[idx] = v;
                shown_value[idx] = acc_value[idx];
              end
              MODE_MEAN: begin
                acc_value[idx]   = acc_value[idx] + v;
                shown_value[idx] = acc_value[idx] / sample_tally[idx];
              end
              MODE_SUM: begin
                acc_value[idx]   = acc_value[idx] + v;
                shown_value[idx] = acc_value[idx];
              end
              MODE_LAST: begin
                acc_value[idx]   = v;
                shown_value[idx] = v;
              end
              default: ;
            endcase
          end
        end
      end
      r.result_value = shown_value[idx];
      r.sample_count = sample_tally[idx];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%08h, want 0x%08h", name, got, want));
  endtask

  task automatic queue_word(logic op, logic [2:0] inst, logic [2:0] fld, logic [31:0] sample);
    item_t w;
    w.operation    = op;
    w.instance_sel = inst;
    w.field_sel    = fld;
    w.sample_value = sample;
    pending_words.push_back(w);
  endtask

  // Hold until every word is sent and answered and the table is quiet, then let the
  // longest update drain before touching the registers.
  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_results.size() != 0 || cmd_start || cmd_busy)
      @(posedge clk_i);
    repeat (VALUE_BITS + 3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_FIELD_COUNT:    field_count_cfg    = data[3:0];
      CFG_INSTANCE_COUNT: instance_count_cfg = data[3:0];
      CFG_FIELD_MODES:    field_modes_cfg    = data;
      CFG_INTERVAL_MODE:  interval_cfg       = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(logic [3:0] fc, logic [3:0] ic, logic [CFG_DATA_W-1:0] modes,
                              logic interval);
    wait_idle();
    write_reg(CFG_FIELD_COUNT, CFG_DATA_W'(fc));
    write_reg(CFG_INSTANCE_COUNT, CFG_DATA_W'(ic));
    write_reg(CFG_FIELD_MODES, modes);
    write_reg(CFG_INTERVAL_MODE, CFG_DATA_W'(interval));
    register_settings++;
  endtask

  // Mostly well-formed addresses with random content; the rest lands anywhere.
  task automatic queue_random_words(int n);
    int unsigned fc;
    int unsigned ic;
    logic [2:0]  inst;
    logic [2:0]  fld;
    logic        op;
    logic [31:0] sample;
    fc = clamp_count(field_count_cfg, MAX_FIELDS);
    ic = clamp_count(instance_count_cfg, MAX_INSTANCES);
    repeat (n) begin
      if (fc != 0 && ic != 0 && $urandom_range(99) < 88) begin
        inst = 3'($urandom_range(ic - 1));
        fld  = 3'($urandom_range(fc - 1));
      end else begin
        inst = 3'($urandom);
        fld  = 3'($urandom);
      end
      op = ($urandom_range(99) < 25) ? OP_READ : OP_PUSH;
      case ($urandom_range(3))
        0:       sample = $urandom;
        1:       sample = $urandom_range(255);
        2:       sample = $urandom_range(1) ? '1 : '0;
        default: sample = 32'h7FFF_FF00 + $urandom_range(511);
      endcase
      queue_word(op, inst, fld, sample);
    end
  endtask

  // Driver: on a taken word, predict its result; then offer the next word, or idle.
  // Hold the current word while the table is busy.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_start && !cmd_busy) begin
        expected_results.push_back(apply_to_table(cmd_word));
        words_accepted++;
      end
      if (!cmd_start || !cmd_busy) begin
        if (pending_words.size() != 0 && (quiet_stretch || $urandom_range(99) >= 13)) begin
          cmd_start <= 1'b1;
          cmd_word  <= pending_words.pop_front();
        end else begin
          cmd_start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result word must match the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && res_strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with no command outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("result_value", res_word.result_value, want.result_value);
        check_field("sample_count", res_word.sample_count, want.sample_count);
        check_field("baseline_only", 32'(res_word.baseline_only), 32'(want.baseline_only));
        check_field("bad_index", 32'(res_word.bad_index), 32'(want.bad_index));
        results_checked++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (shown_value[i]) begin
      acc_value[i]      = '0;
      shown_value[i]    = '0;
      sample_tally[i]   = '0;
      last_sample[i]    = '0;
      baseline_taken[i] = 1'b0;
    end

    // Hold reset low, then release it; the table then sweeps itself clear while busy.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full table, one field per mode, raw samples.
    apply_config(4'd8, 4'd8, MIXED_MODES, 1'b0);
    queue_word(OP_READ, 3'd0, 3'd0, 32'h0);            // never written: zero
    queue_word(OP_PUSH, 3'd0, 3'd0, 32'h0);            // max
    queue_word(OP_PUSH, 3'd0, 3'd0, 32'hFFFF_FFFF);
    queue_word(OP_PUSH, 3'd0, 3'd0, 32'd5);
    queue_word(OP_PUSH, 3'd0, 3'd1, 32'hFFFF_FFFF);    // min
    queue_word(OP_PUSH, 3'd0, 3'd1, 32'h0);
    queue_word(OP_PUSH, 3'd0, 3'd2, 32'hFFFF_FFFF);    // mean, sum wraps
    queue_word(OP_PUSH, 3'd0, 3'd2, 32'd3);
    queue_word(OP_PUSH, 3'd0, 3'd2, 32'd7);
    queue_word(OP_PUSH, 3'd0, 3'd3, 32'hFFFF_FFFF);    // sum wraps
    queue_word(OP_PUSH, 3'd0, 3'd3, 32'd2);
    queue_word(OP_PUSH, 3'd0, 3'd4, 32'd9);            // last
    queue_word(OP_PUSH, 3'd0, 3'd4, 32'd1);
    queue_word(OP_PUSH, 3'd0, 3'd5, 32'd4);            // none keeps the first sample
    queue_word(OP_PUSH, 3'd0, 3'd5, 32'd8);
    queue_word(OP_PUSH, 3'd0, 3'd6, 32'd1);            // spare code acts as none
    queue_word(OP_PUSH, 3'd0, 3'd6, 32'd2);
    queue_word(OP_PUSH, 3'd7, 3'd7, 32'd1);            // top entry
    queue_word(OP_READ, 3'd7, 3'd7, 32'hFFFF_FFFF);

    // Narrow table: addresses past either count are flagged and change nothing.
    apply_config(4'd3, 4'd2, MIXED_MODES, 1'b0);
    queue_word(OP_PUSH, 3'd2, 3'd0, 32'd77);
    queue_word(OP_READ, 3'd0, 3'd3, 32'd0);
    queue_word(OP_READ, 3'd1, 3'd2, 32'd0);

    // Interval mode: baseline push, then a difference that wraps, then a zero difference.
    apply_config(4'd8, 4'd8, MIXED_MODES, 1'b1);
    queue_word(OP_PUSH, 3'd1, 3'd0, 32'd10);
    queue_word(OP_PUSH, 3'd1, 3'd0, 32'd3);
    queue_word(OP_PUSH, 3'd1, 3'd0, 32'd3);

    // Random traffic over a spread of settings, extremes first.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: apply_config(4'd8, 4'd8, ALL_SPARE, 1'b1);
        1: apply_config(4'd1, 4'd1, '0, 1'b0);
        2: apply_config(4'd0, 4'd0, CFG_DATA_W'($urandom), 1'b0);    // every address bad
        3: apply_config(4'd15, 4'd9, CFG_DATA_W'($urandom), 1'b0);   // both counts clamp
        4: apply_config(4'd8, 4'd8, ALL_MEAN, 1'b0);
        5: apply_config(4'd8, 4'd8, ALL_MEAN, 1'b1);
        default: apply_config(4'($urandom_range(8, 1)), 4'($urandom_range(8, 1)),
                              CFG_DATA_W'($urandom), 1'($urandom_range(1)));
      endcase
      queue_random_words((phase == 2) ? 20 : 95);
    end

    // Drain, then let the slowest update settle before the verdict.
    wait_idle();
    $display("Covered %0d command words and %0d result words over %0d register settings",
             words_accepted, results_checked, register_settings);
    $display("Modes max, min, mean, sum, last and none, raw and interval, bad and clamped counts");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/sacc_pkg.sv
rtl/core/sacc_ctrl.sv
rtl/core/sacc_dpath.sv
rtl/core/stats_accumulator_table_top.sv
test/stats_accumulator_table_top_tb.sv
